FILE: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, constants and index helpers for the spike cross-correlogram.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // field widths of the channels
  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int MARK_W     = 4;
  localparam int GROUP_W    = 2;
  localparam int BIN_IDX_W  = 5;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 32;
  localparam int BS_W       = 16;
  localparam int HB_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // histogram geometry
  localparam int MAX_MARKS   = 8;
  localparam int MAX_GROUPS  = 2;
  localparam int MAX_BINS    = 32;
  localparam int MARK_IDX_W  = $clog2(MAX_MARKS);
  localparam int GROUP_IDX_W = $clog2(MAX_GROUPS);
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int PAIR_TOTAL  = MAX_GROUPS * MAX_GROUPS * MAX_MARKS * MAX_MARKS * MAX_BINS;
  localparam int PAIR_AW     = $clog2(PAIR_TOTAL);
  localparam int SPIKE_TOTAL = MAX_GROUPS * MAX_MARKS;
  localparam int SPIKE_AW    = $clog2(SPIKE_TOTAL);

  // a paired difference stays below bin_size * MAX_BINS
  localparam int DIFF_W = BS_W + BIN_W;
  localparam int EDGE_W = BS_W + BIN_W + 1;
  localparam int STEP_W = $clog2(BIN_W);

  typedef enum logic [OP_W-1:0] {
    OP_SPIKE      = 2'd0,
    OP_READ_PAIR  = 2'd1,
    OP_READ_SPIKE = 2'd2,
    OP_UNUSED     = 2'd3
  } scc_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_INDEX = 2'd3
  } scc_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_SIZE  = 2'd0,
    CFG_HALF_BINS = 2'd1,
    CFG_SPARE2    = 2'd2,
    CFG_SPARE3    = 2'd3
  } scc_cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE,
    S_PRUNE_RD,
    S_PRUNE_CHK,
    S_PAIR_RD,
    S_PAIR_DIFF,
    S_PAIR_DIV,
    S_PCNT_WR,
    S_COMMIT,
    S_READ_WAIT,
    S_RESP
  } scc_state_t;

  // one buffered spike
  typedef struct packed {
    logic [TIME_W-1:0]      time_stamp;
    logic [MARK_IDX_W-1:0]  mark;
    logic [GROUP_IDX_W-1:0] group;
  } scc_win_entry_t;

  // access to the pair count memory
  typedef struct packed {
    logic               we;
    logic [PAIR_AW-1:0] waddr;
    logic [COUNT_W-1:0] wdata;
    logic [PAIR_AW-1:0] raddr;
  } scc_pmem_req_t;

  function automatic logic mark_ok(logic [MARK_W-1:0] m);
    return (m != '0) && (int'(m) <= MAX_MARKS);
  endfunction

  function automatic logic group_ok(logic [GROUP_W-1:0] g);
    return (g != '0) && (int'(g) <= MAX_GROUPS);
  endfunction

  // zero-based groups and marks, bin below MAX_BINS
  function automatic logic [PAIR_AW-1:0] pair_slot(
    logic [GROUP_IDX_W-1:0] ga,
    logic [GROUP_IDX_W-1:0] gb,
    logic [MARK_IDX_W-1:0]  ma,
    logic [MARK_IDX_W-1:0]  mb,
    logic [BIN_W-1:0]       bin
  );
    logic [PAIR_AW-1:0] s;
    s = PAIR_AW'(ga);
    s = s * PAIR_AW'(MAX_GROUPS) + PAIR_AW'(gb);
    s = s * PAIR_AW'(MAX_MARKS) + PAIR_AW'(ma);
    s = s * PAIR_AW'(MAX_MARKS) + PAIR_AW'(mb);
    s = s * PAIR_AW'(MAX_BINS) + PAIR_AW'(bin);
    return s;
  endfunction

  function automatic logic [SPIKE_AW-1:0] spike_slot(
    logic [GROUP_IDX_W-1:0] g,
    logic [MARK_IDX_W-1:0]  m
  );
    return SPIKE_AW'(g) * SPIKE_AW'(MAX_MARKS) + SPIKE_AW'(m);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/scc_if.sv
// ----------------------------------------------------------------------------
// scc_in_if / scc_out_if / scc_cfg_if
// Valid/ready channels of the spike cross-correlogram.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_in_if;
  logic                             valid;
  logic                             ready;
  logic [scc_pkg::OP_W-1:0]         operation;
  logic [scc_pkg::TIME_W-1:0]       time_stamp;
  logic [scc_pkg::MARK_W-1:0]       first_mark;
  logic [scc_pkg::GROUP_W-1:0]      first_group;
  logic [scc_pkg::MARK_W-1:0]       second_mark;
  logic [scc_pkg::GROUP_W-1:0]      second_group;
  logic [scc_pkg::BIN_IDX_W-1:0]    bin_index;

  modport source (output valid, operation, time_stamp, first_mark, first_group,
                  second_mark, second_group, bin_index, input ready);
  modport sink   (input valid, operation, time_stamp, first_mark, first_group,
                  second_mark, second_group, bin_index, output ready);
endinterface

interface scc_out_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::STATUS_W-1:0]  status;
  logic [scc_pkg::COUNT_W-1:0]   count_value;

  modport source (output valid, status, count_value, input ready);
  modport sink   (input valid, status, count_value, output ready);
endinterface

interface scc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scc_pkg::CFG_IDX_W-1:0]   index;
  logic [scc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/scc_bin_div.sv
// ----------------------------------------------------------------------------
// scc_bin_div
// Shift-subtract unit: bin = difference / bin_size, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_bin_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [scc_pkg::DIFF_W-1:0]  dividend,
  input  wire logic [scc_pkg::BS_W-1:0]    divisor,
  output logic                             done,
  output logic [scc_pkg::BIN_W-1:0]        quotient
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [scc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [scc_pkg::DIFF_W-1:0]   rem_r, rem_nxt;
  logic [scc_pkg::BIN_W-1:0]    q_r, q_nxt;
  logic [scc_pkg::DIFF_W-1:0]   trial;

  // one compare and subtract per step, highest quotient bit first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = scc_pkg::DIFF_W'(divisor) << step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = scc_pkg::STEP_W'(scc_pkg::BIN_W - 1);
      rem_nxt  = dividend;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt        = rem_r - trial;
        q_nxt[step_r]  = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

FILE: rtl/scc_window_mem.sv
// ----------------------------------------------------------------------------
// scc_window_mem
// Circular store of recent spikes: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_window_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire scc_pkg::scc_win_entry_t wr_data,
  input  wire logic [AW-1:0]           rd_addr,
  output scc_pkg::scc_win_entry_t      rd_data
);

  scc_pkg::scc_win_entry_t mem [DEPTH];

  // write the newest spike, read one entry a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/scc_pair_mem.sv
// ----------------------------------------------------------------------------
// scc_pair_mem
// Pair histogram counters: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_pair_mem (
  input  wire logic                        clk,
  input  wire scc_pkg::scc_pmem_req_t      req,
  output logic [scc_pkg::COUNT_W-1:0]      rd_data
);

  logic [scc_pkg::COUNT_W-1:0] mem [scc_pkg::PAIR_TOTAL];

  // update one counter, read one counter
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/spike_cross_correlogram.sv
// ----------------------------------------------------------------------------
// spike_cross_correlogram
// Streaming cross-correlogram: pairs each spike with the buffered window and
// counts pairs per (groups, marks, bin); reads return stored counts.
// ----------------------------------------------------------------------------
//  channel  | dir | words
//  in_ch    | in  | operation, time_stamp, marks, groups, bin_index
//  out_ch   | out | status, count_value (one per input word)
//  cfg_ch   | in  | index (0 bin_size, 1 half_bins), data
//
//  After reset a clearing pass writes zero to all PAIR_TOTAL (8192) pair
//  counters, one per cycle; in_ch.ready stays low for that time.
//  A spike word first drops the stale entries at the window tail, then
//  handles each buffered spike as a pair: a window read, a divider launch,
//  the shift-subtract bin divider (5 steps) and a read-modify-write of the
//  pair memory. One word is in work at a time; a finished result waits in
//  the output register while the next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_cross_correlogram #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scc_in_if.sink     in_ch,
  scc_out_if.source  out_ch,
  scc_cfg_if.sink    cfg_ch
);

  localparam int WIN_AW = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  scc_pkg::scc_state_t state_r, state_nxt;

  logic [scc_pkg::PAIR_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [scc_pkg::BS_W-1:0]        bin_size_r, bin_size_nxt;
  logic [scc_pkg::HB_W-1:0]        half_bins_r, half_bins_nxt;
  logic [WIN_AW-1:0]               head_r, head_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic [scc_pkg::TIME_W-1:0]      last_time_r, last_time_nxt;
  logic [scc_pkg::COUNT_W-1:0]     spike_cnt_r [scc_pkg::SPIKE_TOTAL];
  logic [scc_pkg::COUNT_W-1:0]     spike_cnt_nxt [scc_pkg::SPIKE_TOTAL];
  logic                            out_valid_r, out_valid_nxt;

  logic [scc_pkg::TIME_W-1:0]      t_r, t_nxt;
  logic [scc_pkg::MARK_IDX_W-1:0]  m1_r, m1_nxt;
  logic [scc_pkg::GROUP_IDX_W-1:0] g1_r, g1_nxt;
  logic [scc_pkg::EDGE_W-1:0]      edge_r, edge_nxt;
  logic [scc_pkg::BS_W-1:0]        bs_r, bs_nxt;
  logic [scc_pkg::BIN_W-1:0]       hb_r, hb_nxt;
  logic [WIN_AW-1:0]               ptr_r, ptr_nxt;
  logic [FILL_W-1:0]               k_r, k_nxt;
  logic [scc_pkg::MARK_IDX_W-1:0]  ent_m_r, ent_m_nxt;
  logic [scc_pkg::GROUP_IDX_W-1:0] ent_g_r, ent_g_nxt;
  logic [scc_pkg::PAIR_AW-1:0]     pslot_r, pslot_nxt;
  scc_pkg::scc_status_t            res_status_r, res_status_nxt;
  logic [scc_pkg::COUNT_W-1:0]     res_value_r, res_value_nxt;
  scc_pkg::scc_status_t            out_status_r, out_status_nxt;
  logic [scc_pkg::COUNT_W-1:0]     out_value_r, out_value_nxt;

  // decoded input fields
  logic [scc_pkg::MARK_W-1:0]      m1_dec, m2_dec;
  logic [scc_pkg::GROUP_W-1:0]     g1_dec, g2_dec;
  logic                            m1_ok, m2_ok, g1_ok, g2_ok, bin_ok;

  // window, divider and memory hookup
  logic [WIN_AW-1:0]               win_rd_addr, win_wr_addr;
  logic                            win_wr_en;
  scc_pkg::scc_win_entry_t         win_wr_data, win_rd_data;
  logic                            div_start, div_done;
  logic [scc_pkg::BIN_W-1:0]       div_q, bin_c;
  scc_pkg::scc_pmem_req_t          pmem_req;
  logic [scc_pkg::COUNT_W-1:0]     pmem_rd;

  logic [FILL_W:0]                 tail_sum;
  logic [WIN_AW-1:0]               tail_c;
  logic [scc_pkg::TIME_W-1:0]      diff_c;
  logic [scc_pkg::BS_W-1:0]        bs_eff;
  logic [scc_pkg::BIN_W-1:0]       hb_eff;
  logic [scc_pkg::SPIKE_AW-1:0]    sslot_c;

  assign in_ch.ready        = (state_r == scc_pkg::S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.count_value = out_value_r;

  // zero-based indices of the incoming word
  assign m1_dec = in_ch.first_mark - 1'b1;
  assign g1_dec = in_ch.first_group - 1'b1;
  assign m2_dec = in_ch.second_mark - 1'b1;
  assign g2_dec = in_ch.second_group - 1'b1;
  assign m1_ok  = scc_pkg::mark_ok(in_ch.first_mark);
  assign g1_ok  = scc_pkg::group_ok(in_ch.first_group);
  assign m2_ok  = scc_pkg::mark_ok(in_ch.second_mark);
  assign g2_ok  = scc_pkg::group_ok(in_ch.second_group);
  assign bin_ok = int'(in_ch.bin_index) < scc_pkg::MAX_BINS;

  // oldest live window slot
  assign tail_sum = (FILL_W + 1)'(head_r) + (FILL_W + 1)'(WINDOW_DEPTH) - (FILL_W + 1)'(fill_r);
  assign tail_c   = (int'(tail_sum) >= WINDOW_DEPTH) ?
                    WIN_AW'(tail_sum - (FILL_W + 1)'(WINDOW_DEPTH)) : WIN_AW'(tail_sum);

  assign diff_c  = t_r - win_rd_data.time_stamp;
  assign bs_eff  = (bin_size_r == '0) ? scc_pkg::BS_W'(1) : bin_size_r;
  assign hb_eff  = (int'(half_bins_r) > scc_pkg::MAX_BINS - 1) ?
                   scc_pkg::BIN_W'(scc_pkg::MAX_BINS - 1) : scc_pkg::BIN_W'(half_bins_r);
  assign bin_c   = (div_q > hb_r) ? hb_r : div_q;
  assign sslot_c = scc_pkg::spike_slot(g1_r, m1_r);

  assign win_wr_data.time_stamp = t_r;
  assign win_wr_data.mark       = m1_r;
  assign win_wr_data.group      = g1_r;
  assign win_wr_addr            = head_r;

  scc_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (WIN_AW)
  ) u_window (
    .clk     (clk),
    .wr_en   (win_wr_en),
    .wr_addr (win_wr_addr),
    .wr_data (win_wr_data),
    .rd_addr (win_rd_addr),
    .rd_data (win_rd_data)
  );

  scc_bin_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_c[scc_pkg::DIFF_W-1:0]),
    .divisor  (bs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  scc_pair_mem u_pair_mem (
    .clk     (clk),
    .req     (pmem_req),
    .rd_data (pmem_rd)
  );

  // sequencer: next state, datapath control and register updates
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    bin_size_nxt   = bin_size_r;
    half_bins_nxt  = half_bins_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    last_time_nxt  = last_time_r;
    spike_cnt_nxt  = spike_cnt_r;
    out_valid_nxt  = out_valid_r;
    t_nxt          = t_r;
    m1_nxt         = m1_r;
    g1_nxt         = g1_r;
    edge_nxt       = edge_r;
    bs_nxt         = bs_r;
    hb_nxt         = hb_r;
    ptr_nxt        = ptr_r;
    k_nxt          = k_r;
    ent_m_nxt      = ent_m_r;
    ent_g_nxt      = ent_g_r;
    pslot_nxt      = pslot_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    win_rd_addr    = ptr_r;
    win_wr_en      = 1'b0;
    div_start      = 1'b0;
    pmem_req.we    = 1'b0;
    pmem_req.waddr = pslot_r;
    pmem_req.wdata = pmem_rd + 1'b1;
    pmem_req.raddr = pslot_r;

    // register writes
    if (cfg_ch.valid) begin
      case (scc_pkg::scc_cfg_idx_t'(cfg_ch.index))
        scc_pkg::CFG_BIN_SIZE:  bin_size_nxt  = scc_pkg::BS_W'(cfg_ch.data);
        scc_pkg::CFG_HALF_BINS: half_bins_nxt = cfg_ch.data[scc_pkg::HB_W-1:0];
        default: ;
      endcase
    end

    // drop the result word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      scc_pkg::S_CLEAR: begin
        pmem_req.we    = 1'b1;
        pmem_req.waddr = clr_addr_r;
        pmem_req.wdata = '0;
        clr_addr_nxt   = clr_addr_r + 1'b1;
        if (int'(clr_addr_r) == scc_pkg::PAIR_TOTAL - 1) begin
          state_nxt = scc_pkg::S_IDLE;
        end
      end

      scc_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          t_nxt          = in_ch.time_stamp;
          m1_nxt         = m1_dec[scc_pkg::MARK_IDX_W-1:0];
          g1_nxt         = g1_dec[scc_pkg::GROUP_IDX_W-1:0];
          res_status_nxt = scc_pkg::ST_OK;
          res_value_nxt  = '0;
          state_nxt      = scc_pkg::S_RESP;
          case (scc_pkg::scc_op_t'(in_ch.operation))
            scc_pkg::OP_SPIKE: begin
              if (!(m1_ok && g1_ok)) begin
                res_status_nxt = scc_pkg::ST_INDEX;
              end else if (in_ch.time_stamp < last_time_r) begin
                res_status_nxt = scc_pkg::ST_ORDER;
              end else begin
                state_nxt = scc_pkg::S_EDGE;
              end
            end
            scc_pkg::OP_READ_PAIR: begin
              if (m1_ok && g1_ok && m2_ok && g2_ok && bin_ok) begin
                pmem_req.raddr = scc_pkg::pair_slot(
                  g1_dec[scc_pkg::GROUP_IDX_W-1:0], g2_dec[scc_pkg::GROUP_IDX_W-1:0],
                  m1_dec[scc_pkg::MARK_IDX_W-1:0], m2_dec[scc_pkg::MARK_IDX_W-1:0],
                  scc_pkg::BIN_W'(in_ch.bin_index));
                state_nxt = scc_pkg::S_READ_WAIT;
              end else begin
                res_status_nxt = scc_pkg::ST_INDEX;
              end
            end
            scc_pkg::OP_READ_SPIKE: begin
              if (m1_ok && g1_ok) begin
                res_value_nxt = spike_cnt_r[scc_pkg::spike_slot(
                  g1_dec[scc_pkg::GROUP_IDX_W-1:0], m1_dec[scc_pkg::MARK_IDX_W-1:0])];
              end else begin
                res_status_nxt = scc_pkg::ST_INDEX;
              end
            end
            default: res_status_nxt = scc_pkg::ST_INDEX;
          endcase
        end
      end

      scc_pkg::S_READ_WAIT: begin
        res_value_nxt = pmem_rd;
        state_nxt     = scc_pkg::S_RESP;
      end

      // latch the pairing edge and bin size for this spike
      scc_pkg::S_EDGE: begin
        bs_nxt    = bs_eff;
        hb_nxt    = hb_eff;
        edge_nxt  = scc_pkg::EDGE_W'(bs_eff) * (scc_pkg::EDGE_W'(hb_eff) + 1'b1);
        state_nxt = scc_pkg::S_PRUNE_RD;
      end

      scc_pkg::S_PRUNE_RD: begin
        win_rd_addr = tail_c;
        ptr_nxt     = tail_c;
        k_nxt       = '0;
        state_nxt   = (fill_r == '0) ? scc_pkg::S_PAIR_RD : scc_pkg::S_PRUNE_CHK;
      end

      // drop the oldest entry while it is out of reach
      scc_pkg::S_PRUNE_CHK: begin
        if (diff_c >= scc_pkg::TIME_W'(edge_r)) begin
          fill_nxt  = fill_r - 1'b1;
          state_nxt = scc_pkg::S_PRUNE_RD;
        end else begin
          state_nxt = scc_pkg::S_PAIR_RD;
        end
      end

      scc_pkg::S_PAIR_RD: begin
        if (k_r == fill_r) begin
          state_nxt = scc_pkg::S_COMMIT;
        end else begin
          state_nxt = scc_pkg::S_PAIR_DIFF;
        end
      end

      scc_pkg::S_PAIR_DIFF: begin
        div_start = 1'b1;
        ent_m_nxt = win_rd_data.mark;
        ent_g_nxt = win_rd_data.group;
        state_nxt = scc_pkg::S_PAIR_DIV;
      end

      scc_pkg::S_PAIR_DIV: begin
        if (div_done) begin
          pslot_nxt      = scc_pkg::pair_slot(ent_g_r, g1_r, ent_m_r, m1_r, bin_c);
          pmem_req.raddr = pslot_nxt;
          state_nxt      = scc_pkg::S_PCNT_WR;
        end
      end

      // increment the counter and advance to the next buffered spike
      scc_pkg::S_PCNT_WR: begin
        pmem_req.we = 1'b1;
        k_nxt       = k_r + 1'b1;
        ptr_nxt     = (int'(ptr_r) == WINDOW_DEPTH - 1) ? '0 : ptr_r + 1'b1;
        win_rd_addr = ptr_nxt;
        state_nxt   = scc_pkg::S_PAIR_RD;
      end

      scc_pkg::S_COMMIT: begin
        win_wr_en              = 1'b1;
        spike_cnt_nxt[sslot_c] = spike_cnt_r[sslot_c] + 1'b1;
        head_nxt               = (int'(head_r) == WINDOW_DEPTH - 1) ? '0 : head_r + 1'b1;
        last_time_nxt          = t_r;
        if (int'(fill_r) >= WINDOW_DEPTH) begin
          res_status_nxt = scc_pkg::ST_FULL;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = scc_pkg::S_RESP;
      end

      // hold until the output register is free
      scc_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = scc_pkg::S_IDLE;
        end
      end

      default: state_nxt = scc_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scc_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      bin_size_r  <= scc_pkg::BS_W'(1);
      half_bins_r <= scc_pkg::HB_W'(31);
      head_r      <= '0;
      fill_r      <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < scc_pkg::SPIKE_TOTAL; i++) begin
        spike_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      bin_size_r  <= bin_size_nxt;
      half_bins_r <= half_bins_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
      spike_cnt_r <= spike_cnt_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    m1_r         <= m1_nxt;
    g1_r         <= g1_nxt;
    edge_r       <= edge_nxt;
    bs_r         <= bs_nxt;
    hb_r         <= hb_nxt;
    ptr_r        <= ptr_nxt;
    k_r          <= k_nxt;
    ent_m_r      <= ent_m_nxt;
    ent_g_r      <= ent_g_nxt;
    pslot_r      <= pslot_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // no word is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::S_CLEAR) |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // window occupancy never exceeds its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= WINDOW_DEPTH)
    else $error("window fill above depth");

  // a paired spike survived pruning, so its bin is in range
  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scc_pkg::S_PAIR_DIV && div_done) |-> (div_q <= hb_r))
    else $error("paired difference beyond the last bin");

endmodule

`default_nettype wire
